### hw/rtl/key_event_translator_tracker_core_assert.svh
// assertion macros for the key event translator tracker
`ifndef KEY_EVENT_TRANSLATOR_TRACKER_CORE_ASSERT_SVH
`define KEY_EVENT_TRANSLATOR_TRACKER_CORE_ASSERT_SVH

// condition that holds at every edge outside reset
`define KETT_ASSERT_ALWAYS(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("key event tracker: invariant violated");

// implication checked on the following edge
`define KETT_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("key event tracker: sequence violated");

`endif

### hw/rtl/kett_pkg.sv
`default_nettype none

package kett_pkg;

   localparam int MAX_HELD_DEF = 16;

   localparam logic [31:0] LEGAL_MASK = 32'h0070_00ff;
   localparam int SHIFT_POS = 20;
   localparam int CTRL_POS  = 21;
   localparam int ALT_POS   = 22;

   localparam logic [15:0] SYM_TAB = 16'hff09;
   localparam logic [15:0] SYM_CR  = 16'hff0d;
   localparam logic [15:0] SYM_ESC = 16'hff1b;
   localparam logic [6:0]  CODE_TAB = 7'h17;
   localparam logic [6:0]  CODE_CR  = 7'h24;
   localparam logic [6:0]  CODE_ESC = 7'h09;

   localparam logic [6:0] LETTER_CODES [26] = '{
      7'h26, 7'h38, 7'h36, 7'h28, 7'h1a, 7'h29, 7'h2a, 7'h2b, 7'h1f,
      7'h2c, 7'h2d, 7'h2e, 7'h3a, 7'h39, 7'h20, 7'h21, 7'h18, 7'h1b,
      7'h27, 7'h1c, 7'h1e, 7'h37, 7'h19, 7'h35, 7'h1d, 7'h34
   };

   localparam logic [15:0] NAV_SYMBOLS [10] = '{
      16'hffff, 16'hff08, 16'hff55, 16'hff56, 16'hff54,
      16'hff52, 16'hff51, 16'hff53, 16'hff50, 16'hff57
   };

   localparam logic [6:0] NAV_CODES [10] = '{
      7'h77, 7'h16, 7'h70, 7'h75, 7'h74, 7'h6f, 7'h71, 7'h72, 7'h6e, 7'h73
   };

   typedef struct packed {
      logic [6:0]  code;
      logic [15:0] sym;
      logic [2:0]  mods;
   } slot_type;

   typedef struct packed {
      logic     ok;
      slot_type key;
   } xlat_type;

   typedef struct packed {
      logic capture;
      logic store;
      logic take_hit;
      logic take_first;
   } dp_cmd_type;

   typedef struct packed {
      logic key_ok;
      logic key_down;
      logic hit;
      logic free;
      logic any_valid;
      logic last;
   } dp_sts_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOOKUP,
      ST_READ,
      ST_SEND
   } state_type;

   function automatic logic [6:0] printable_code(input logic [7:0] b);
      logic [6:0] c;
      c = 7'h00;
      if (b inside {[8'd65:8'd90]}) begin
         c = LETTER_CODES[5'(b - 8'd65)];
      end else if (b inside {[8'd49:8'd57]}) begin
         c = 7'(b - 8'd49) + 7'h0a;
      end else begin
         case (b)
            8'd48, 8'd41:  c = 7'h13;
            8'd33:         c = 7'h0a;
            8'd64:         c = 7'h0b;
            8'd35:         c = 7'h0c;
            8'd36:         c = 7'h0d;
            8'd37:         c = 7'h0e;
            8'd94:         c = 7'h0f;
            8'd38:         c = 7'h10;
            8'd42:         c = 7'h11;
            8'd40:         c = 7'h12;
            8'd45, 8'd95:  c = 7'h14;
            8'd61, 8'd43:  c = 7'h15;
            8'd91, 8'd123: c = 7'h22;
            8'd93, 8'd125: c = 7'h23;
            8'd59, 8'd58:  c = 7'h2f;
            8'd39, 8'd34:  c = 7'h30;
            8'd96, 8'd126: c = 7'h31;
            8'd92, 8'd124: c = 7'h33;
            8'd44, 8'd60:  c = 7'h3b;
            8'd46, 8'd62:  c = 7'h3c;
            8'd47, 8'd63:  c = 7'h3d;
            8'd32:         c = 7'h41;
            default:       c = 7'h00;
         endcase
      end
      return c;
   endfunction

   function automatic xlat_type translate(input logic [31:0] raw);
      xlat_type   r;
      logic [7:0] b;
      b = raw[7:0];
      r = '0;
      r.key.mods = {raw[ALT_POS], raw[SHIFT_POS], raw[CTRL_POS]};
      if ((raw & ~LEGAL_MASK) != 32'h0) begin
         r.ok = 1'b0;
      end else if (b inside {[8'd32:8'd96], [8'd123:8'd126]}) begin
         r.ok = 1'b1;
         if (b inside {[8'd65:8'd90]} && !raw[SHIFT_POS]) begin
            r.key.sym = {8'h00, b + 8'd32};
         end else begin
            r.key.sym = {8'h00, b};
         end
         r.key.code = printable_code(b);
      end else if (b == 8'd9) begin
         r.ok = 1'b1;
         r.key.sym = SYM_TAB;
         r.key.code = CODE_TAB;
      end else if (b == 8'd13) begin
         r.ok = 1'b1;
         r.key.sym = SYM_CR;
         r.key.code = CODE_CR;
      end else if (b == 8'd27) begin
         r.ok = 1'b1;
         r.key.sym = SYM_ESC;
         r.key.code = CODE_ESC;
      end else if (b inside {[8'd127:8'd136]}) begin
         r.ok = 1'b1;
         r.key.sym = NAV_SYMBOLS[4'(b - 8'd127)];
         r.key.code = NAV_CODES[4'(b - 8'd127)];
      end else begin
         r.ok = 1'b0;
      end
      return r;
   endfunction

endpackage

`default_nettype wire

### hw/rtl/kett_dp.sv
`default_nettype none

module kett_dp #(
   parameter int MAX_HELD = kett_pkg::MAX_HELD_DEF
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire kett_pkg::dp_cmd_type   cmd,
   output kett_pkg::dp_sts_type        sts,
   input  wire logic [31:0]            raw_code,
   input  wire logic                   key_down,
   output logic [6:0]                  key_code,
   output logic [15:0]                 key_symbol,
   output logic [2:0]                  modifier_bits,
   output logic                        is_press,
   output logic                        last
);

   localparam int IdxW = (MAX_HELD > 1) ? $clog2(MAX_HELD) : 1;

   logic [31:0]          raw_ff;
   logic                 down_ff;
   logic [MAX_HELD-1:0]  valid_ff, valid_in;
   logic [7:0]           ident_ff [MAX_HELD];
   kett_pkg::slot_type   slot_mem [MAX_HELD];
   kett_pkg::slot_type   rdata_ff;
   logic                 press_ff, press_in;
   logic                 last_ff, last_in;

   kett_pkg::xlat_type   xl;
   logic [MAX_HELD-1:0]  hit_vec;
   logic [MAX_HELD-1:0]  first_oh;
   logic [IdxW-1:0]      hit_idx, free_idx, first_idx, rd_idx;
   logic                 free_any;
   logic                 rd_en;

   assign xl = kett_pkg::translate(raw_ff);

   // key lookup against the held table
   always_comb begin
      hit_idx   = '0;
      free_idx  = '0;
      first_idx = '0;
      free_any  = 1'b0;
      first_oh  = '0;
      for (int i = 0; i < MAX_HELD; i++) begin
         hit_vec[i] = valid_ff[i] && (ident_ff[i] == raw_ff[7:0]);
         if (hit_vec[i]) begin
            hit_idx = IdxW'(i);
         end
      end
      for (int i = MAX_HELD - 1; i >= 0; i--) begin
         if (!valid_ff[i]) begin
            free_idx = IdxW'(i);
            free_any = 1'b1;
         end
         if (valid_ff[i]) begin
            first_idx = IdxW'(i);
            first_oh  = '0;
            first_oh[i] = 1'b1;
         end
      end
   end

   assign rd_en  = cmd.take_hit || cmd.take_first;
   assign rd_idx = cmd.take_hit ? hit_idx : first_idx;

   always_comb begin
      valid_in = valid_ff;
      press_in = press_ff;
      last_in  = last_ff;
      if (cmd.store) begin
         valid_in[free_idx] = 1'b1;
         press_in = 1'b1;
         last_in  = 1'b1;
      end else if (cmd.take_hit) begin
         valid_in[hit_idx] = 1'b0;
         press_in = 1'b0;
         last_in  = 1'b1;
      end else if (cmd.take_first) begin
         valid_in = valid_ff & ~first_oh;
         press_in = 1'b0;
         last_in  = ((valid_ff & ~first_oh) == '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         press_ff <= 1'b0;
         last_ff  <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         press_ff <= press_in;
         last_ff  <= last_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         raw_ff  <= raw_code;
         down_ff <= key_down;
      end
      if (cmd.store) begin
         ident_ff[free_idx] <= raw_ff[7:0];
      end
   end

   // slot payload store, one write and one registered read port
   always_ff @(posedge clock) begin
      if (cmd.store) begin
         slot_mem[free_idx] <= xl.key;
      end
      if (rd_en) begin
         rdata_ff <= slot_mem[rd_idx];
      end
   end

   always_comb begin
      sts.key_ok    = xl.ok;
      sts.key_down  = down_ff;
      sts.hit       = |hit_vec;
      sts.free      = free_any;
      sts.any_valid = |valid_ff;
      sts.last      = last_ff;
   end

   assign key_code      = press_ff ? xl.key.code : rdata_ff.code;
   assign key_symbol    = press_ff ? xl.key.sym  : rdata_ff.sym;
   assign modifier_bits = press_ff ? xl.key.mods : rdata_ff.mods;
   assign is_press      = press_ff;
   assign last          = last_ff;

endmodule

`default_nettype wire

### hw/rtl/kett_ctrl.sv
`default_nettype none

module kett_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_tvalid,
   output logic                      req_tready,
   output logic                      rsp_tvalid,
   input  wire logic                 rsp_tready,
   input  wire kett_pkg::dp_sts_type sts,
   output kett_pkg::dp_cmd_type      cmd
);

   kett_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= kett_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      case (state_ff)
         kett_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in = kett_pkg::ST_LOOKUP;
            end
         end
         kett_pkg::ST_LOOKUP: begin
            if (sts.key_down) begin
               if (!sts.key_ok || sts.hit) begin
                  state_in = kett_pkg::ST_IDLE;
               end else if (!sts.free) begin
                  state_in = kett_pkg::ST_READ;
               end else begin
                  cmd.store = 1'b1;
                  state_in = kett_pkg::ST_SEND;
               end
            end else if (sts.key_ok && sts.hit) begin
               cmd.take_hit = 1'b1;
               state_in = kett_pkg::ST_SEND;
            end else if (sts.any_valid) begin
               state_in = kett_pkg::ST_READ;
            end else begin
               state_in = kett_pkg::ST_IDLE;
            end
         end
         kett_pkg::ST_READ: begin
            // release the lowest held key
            cmd.take_first = 1'b1;
            state_in = kett_pkg::ST_SEND;
         end
         kett_pkg::ST_SEND: begin
            rsp_tvalid = 1'b1;
            if (rsp_tready) begin
               state_in = sts.last ? kett_pkg::ST_IDLE : kett_pkg::ST_READ;
            end
         end
         default: begin
            state_in = kett_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

### hw/rtl/key_event_translator_tracker_core.sv
// an accepted item is captured, then looked up; a press result or a matched release result is then sent
// a new item is taken only after the last result of the previous item has been sent
// a cancel, or a press on a full table, gives one release result per held key (slot read, then send)
// the slot store has a single read port and the sequencer handles one item at a time
// reset: synchronous active high, clears the held table valid bits and the sequencer
`default_nettype none

module key_event_translator_tracker_core #(
   parameter int MAX_HELD = kett_pkg::MAX_HELD_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,   // raw_code[31:0]
   input  wire logic [0:0]  req_tuser,   // key_down[0]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [31:0]      rsp_tdata,   // key_code[6:0], key_symbol[22:7], modifier_bits[25:23]
   output logic [0:0]       rsp_tuser,   // is_press[0]
   output logic             rsp_tlast
);

   kett_pkg::dp_cmd_type cmd;
   kett_pkg::dp_sts_type sts;
   logic [6:0]           key_code;
   logic [15:0]          key_symbol;
   logic [2:0]           modifier_bits;
   logic                 is_press;
   logic                 last;

   kett_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   kett_dp #(
      .MAX_HELD (MAX_HELD)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .sts           (sts),
      .raw_code      (req_tdata),
      .key_down      (req_tuser[0]),
      .key_code      (key_code),
      .key_symbol    (key_symbol),
      .modifier_bits (modifier_bits),
      .is_press      (is_press),
      .last          (last)
   );

   assign rsp_tdata = {6'b0, modifier_bits, key_symbol, key_code};
   assign rsp_tuser = is_press;
   assign rsp_tlast = last;

endmodule

`default_nettype wire

### hw/rtl/kett_checker.sv
`default_nettype none
`include "key_event_translator_tracker_core_assert.svh"

module kett_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [31:0] rsp_tdata,
   input wire logic [0:0]  rsp_tuser,
   input wire logic        rsp_tlast
);

   // one item at a time: never taking input while a result is shown
   `KETT_ASSERT_ALWAYS(a_no_overlap, clock, reset, !(req_tready && rsp_tvalid))

   // a press result is always the last result of its item
   `KETT_ASSERT_ALWAYS(a_press_last, clock, reset, !(rsp_tvalid && rsp_tuser[0]) || rsp_tlast)

   // after an item is taken the block is busy with its lookup
   `KETT_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_tvalid && req_tready, !req_tready)

   // the final result of an item is followed by a gap
   `KETT_ASSERT_NEXT(a_gap_after_last, clock, reset,
      rsp_tvalid && rsp_tready && rsp_tlast, !rsp_tvalid)

   // stalled result holds
   `KETT_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready,
      rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast))

endmodule

bind key_event_translator_tracker_core kett_checker u_kett_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

`default_nettype wire

### tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

   localparam int HELD_SLOTS = 16;
   localparam int WATCHDOG_LIMIT = 1000;
   localparam int TAIL_CYCLES = 40;
   localparam int RANDOM_TARGET = 120;

   localparam logic [31:0] RAW_LEGAL = 32'h0070_00ff;
   localparam int SHIFT_POS = 20;
   localparam int CTRL_POS  = 21;
   localparam int ALT_POS   = 22;

   localparam logic PRESS   = 1'b1;
   localparam logic RELEASE = 1'b0;

   localparam logic [7:0] BASE_TAB = 8'd9;
   localparam logic [7:0] BASE_CR  = 8'd13;
   localparam logic [7:0] BASE_ESC = 8'd27;
   localparam logic [7:0] BASE_NAV_LO = 8'd127;
   localparam logic [7:0] BASE_NAV_HI = 8'd136;

   localparam logic [6:0] LETTER_KEYCODE [26] = '{
      7'h26, 7'h38, 7'h36, 7'h28, 7'h1a, 7'h29, 7'h2a, 7'h2b, 7'h1f,
      7'h2c, 7'h2d, 7'h2e, 7'h3a, 7'h39, 7'h20, 7'h21, 7'h18, 7'h1b,
      7'h27, 7'h1c, 7'h1e, 7'h37, 7'h19, 7'h35, 7'h1d, 7'h34
   };
   localparam logic [15:0] NAV_KEYSYM [10] = '{
      16'hffff, 16'hff08, 16'hff55, 16'hff56, 16'hff54,
      16'hff52, 16'hff51, 16'hff53, 16'hff50, 16'hff57
   };
   localparam logic [6:0] NAV_KEYCODE [10] = '{
      7'h77, 7'h16, 7'h70, 7'h75, 7'h74, 7'h6f, 7'h71, 7'h72, 7'h6e, 7'h73
   };

   typedef struct packed {
      logic [6:0]  code;
      logic [15:0] sym;
      logic [2:0]  mods;
      logic        press;
      logic        last;
   } key_event_type;

   typedef struct packed {
      logic [31:0]   raw;
      logic          down;
      logic          typed;
      logic          typed_has;
      key_event_type ev;
   } key_row_type;

   localparam key_event_type NO_EVENT = '0;

   localparam key_row_type DIRECTED_ROWS [25] = '{
      '{32'h0000_0041, RELEASE, 1'b1, 1'b0, NO_EVENT},
      '{32'h0000_0041, PRESS,   1'b1, 1'b1, '{7'h26, 16'h0061, 3'd0, 1'b1, 1'b1}},
      '{32'h0000_0041, PRESS,   1'b1, 1'b0, NO_EVENT},
      '{32'h0010_0042, PRESS,   1'b1, 1'b1, '{7'h38, 16'h0042, 3'd2, 1'b1, 1'b1}},
      '{32'h0070_0020, PRESS,   1'b1, 1'b1, '{7'h41, 16'h0020, 3'd7, 1'b1, 1'b1}},
      '{32'h0020_0009, PRESS,   1'b1, 1'b1, '{7'h17, 16'hff09, 3'd1, 1'b1, 1'b1}},
      '{32'h0040_000d, PRESS,   1'b1, 1'b1, '{7'h24, 16'hff0d, 3'd4, 1'b1, 1'b1}},
      '{32'h0000_001b, PRESS,   1'b1, 1'b1, '{7'h09, 16'hff1b, 3'd0, 1'b1, 1'b1}},
      '{32'h0000_007f, PRESS,   1'b1, 1'b1, '{7'h77, 16'hffff, 3'd0, 1'b1, 1'b1}},
      '{32'h0000_0088, PRESS,   1'b1, 1'b1, '{7'h73, 16'hff57, 3'd0, 1'b1, 1'b1}},
      '{32'h0000_0089, PRESS,   1'b1, 1'b0, NO_EVENT},
      '{32'h8000_0041, PRESS,   1'b1, 1'b0, NO_EVENT},
      '{32'h0080_0030, PRESS,   1'b1, 1'b0, NO_EVENT},
      '{32'hffff_ffff, PRESS,   1'b1, 1'b0, NO_EVENT},
      '{32'h0000_007e, PRESS,   1'b0, 1'b0, NO_EVENT},
      '{32'h0010_0060, PRESS,   1'b0, 1'b0, NO_EVENT},
      '{32'h0000_0000, PRESS,   1'b1, 1'b0, NO_EVENT},
      '{32'h0000_0061, PRESS,   1'b1, 1'b0, NO_EVENT},
      '{32'h0070_0041, RELEASE, 1'b1, 1'b1, '{7'h26, 16'h0061, 3'd0, 1'b0, 1'b1}},
      '{32'h0010_0042, RELEASE, 1'b1, 1'b1, '{7'h38, 16'h0042, 3'd2, 1'b0, 1'b1}},
      '{32'h0000_005a, PRESS,   1'b0, 1'b0, NO_EVENT},
      '{32'h0000_0080, RELEASE, 1'b0, 1'b0, NO_EVENT},
      '{32'h0000_0061, RELEASE, 1'b1, 1'b0, NO_EVENT},
      '{32'h0000_005a, PRESS,   1'b0, 1'b0, NO_EVENT},
      '{32'hffff_ffff, RELEASE, 1'b0, 1'b0, NO_EVENT}
   };

   logic        clock;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;    // raw_code[31:0]
   logic [0:0]  req_tuser = '0;    // key_down[0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;         // key_code[6:0], key_symbol[22:7], modifier_bits[25:23]
   logic [0:0]  rsp_tuser;         // is_press[0]
   logic        rsp_tlast;

   key_event_type pending_key_events[$];
   key_event_type predicted[$];
   logic          held_valid [HELD_SLOTS];
   logic [7:0]    held_id [HELD_SLOTS];
   key_event_type held_ev [HELD_SLOTS];

   bit calm = 1'b0;
   int mismatches = 0;
   int items_sent = 0;
   int effective_items = 0;
   int results_checked = 0;
   int table_flushes = 0;
   int full_flushes = 0;
   int quiet_cycles = 0;

   key_event_translator_tracker_core #(
      .MAX_HELD(HELD_SLOTS)
   ) u_dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .rsp_tlast(rsp_tlast)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   task automatic log_mismatch(input string what);
      mismatches++;
      $display("mismatch at %0t: %s", $time, what);
   endtask

   function automatic logic [6:0] glyph_keycode(input logic [7:0] b);
      if (b >= 8'h41 && b <= 8'h5a) return LETTER_KEYCODE[5'(b - 8'h41)];
      if (b >= 8'h31 && b <= 8'h39) return 7'(b - 8'd39);
      case (b)
         8'h30, 8'h29: return 7'h13;
         8'h21:        return 7'h0a;
         8'h40:        return 7'h0b;
         8'h23:        return 7'h0c;
         8'h24:        return 7'h0d;
         8'h25:        return 7'h0e;
         8'h5e:        return 7'h0f;
         8'h26:        return 7'h10;
         8'h2a:        return 7'h11;
         8'h28:        return 7'h12;
         8'h2d, 8'h5f: return 7'h14;
         8'h3d, 8'h2b: return 7'h15;
         8'h5b, 8'h7b: return 7'h22;
         8'h5d, 8'h7d: return 7'h23;
         8'h3b, 8'h3a: return 7'h2f;
         8'h27, 8'h22: return 7'h30;
         8'h60, 8'h7e: return 7'h31;
         8'h5c, 8'h7c: return 7'h33;
         8'h2c, 8'h3c: return 7'h3b;
         8'h2e, 8'h3e: return 7'h3c;
         8'h2f, 8'h3f: return 7'h3d;
         8'h20:        return 7'h41;
         default:      return 7'h00;
      endcase
   endfunction

   function automatic logic translate_key(input logic [31:0] raw, output key_event_type ev);
      logic [7:0] b;
      b = raw[7:0];
      ev = '0;
      ev.mods = {raw[ALT_POS], raw[SHIFT_POS], raw[CTRL_POS]};
      if ((raw & ~RAW_LEGAL) != 32'h0) return 1'b0;
      if ((b >= 8'd32 && b <= 8'd96) || (b >= 8'd123 && b <= 8'd126)) begin
         ev.sym = {8'h00, b};
         if (b >= 8'h41 && b <= 8'h5a && !raw[SHIFT_POS]) ev.sym = {8'h00, b + 8'd32};
         ev.code = glyph_keycode(b);
      end else if (b == BASE_TAB) begin
         ev.sym = 16'hff09;
         ev.code = 7'h17;
      end else if (b == BASE_CR) begin
         ev.sym = 16'hff0d;
         ev.code = 7'h24;
      end else if (b == BASE_ESC) begin
         ev.sym = 16'hff1b;
         ev.code = 7'h09;
      end else if (b >= BASE_NAV_LO && b <= BASE_NAV_HI) begin
         ev.sym = NAV_KEYSYM[4'(b - BASE_NAV_LO)];
         ev.code = NAV_KEYCODE[4'(b - BASE_NAV_LO)];
      end else begin
         return 1'b0;
      end
      return 1'b1;
   endfunction

   task automatic flush_held();
      key_event_type ev;
      for (int i = 0; i < HELD_SLOTS; i++) begin
         if (held_valid[i]) begin
            ev = held_ev[i];
            ev.press = 1'b0;
            ev.last = 1'b0;
            predicted.push_back(ev);
            held_valid[i] = 1'b0;
         end
      end
      if (predicted.size() > 0) begin
         predicted[predicted.size() - 1].last = 1'b1;
         table_flushes++;
      end
   endtask

   task automatic predict_key(input logic [31:0] raw, input logic down);
      key_event_type ev;
      logic          ok;
      int            hit;
      int            open;
      predicted.delete();
      ok = translate_key(raw, ev);
      hit = -1;
      open = -1;
      for (int i = 0; i < HELD_SLOTS; i++) begin
         if (held_valid[i]) begin
            if (held_id[i] == raw[7:0]) hit = i;
         end else if (open < 0) begin
            open = i;
         end
      end
      if (!down) begin
         if (!ok || hit < 0) begin
            flush_held();
         end else begin
            ev = held_ev[hit];
            ev.press = 1'b0;
            ev.last = 1'b1;
            predicted.push_back(ev);
            held_valid[hit] = 1'b0;
         end
      end else if (ok && hit < 0) begin
         if (open < 0) begin
            flush_held();
            full_flushes++;
         end else begin
            ev.press = 1'b1;
            ev.last = 1'b1;
            held_valid[open] = 1'b1;
            held_id[open] = raw[7:0];
            held_ev[open] = ev;
            predicted.push_back(ev);
         end
      end
   endtask

   task automatic send_key(input logic [31:0] raw, input logic down,
                           input logic typed, input logic typed_has,
                           input key_event_type typed_ev);
      calm = (items_sent >= 70 && items_sent < 110);
      while (!calm && $urandom_range(99) < 36) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      predict_key(raw, down);
      if (predicted.size() > 0) effective_items++;
      if (typed) begin
         if (typed_has) pending_key_events.push_back(typed_ev);
      end else begin
         foreach (predicted[i]) pending_key_events.push_back(predicted[i]);
      end
      req_tvalid <= 1'b1;
      req_tdata <= raw;
      req_tuser <= down;
      do @(posedge clock); while (!req_tready);
      items_sent++;
      @(negedge clock);
   endtask

   function automatic logic [7:0] pick_valid_base();
      case ($urandom_range(7))
         0: return 8'($urandom_range(127, 136));
         1: begin
            case ($urandom_range(2))
               0:       return BASE_TAB;
               1:       return BASE_CR;
               default: return BASE_ESC;
            endcase
         end
         2: return 8'($urandom_range(123, 126));
         default: return 8'($urandom_range(32, 96));
      endcase
   endfunction

   function automatic logic [31:0] with_mods(input logic [7:0] base);
      return {9'h0, 3'($urandom_range(7)), 12'h0, base};
   endfunction

   // receiver stalls
   always @(negedge clock) begin
      rsp_tready <= calm || ($urandom_range(99) >= 36);
   end

   always @(posedge clock) begin
      key_event_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         results_checked++;
         if (pending_key_events.size() == 0) begin
            log_mismatch($sformatf("unexpected result data %h user %b last %b",
                                   rsp_tdata, rsp_tuser, rsp_tlast));
         end else begin
            want = pending_key_events.pop_front();
            if (rsp_tdata[6:0] != want.code)
               log_mismatch($sformatf("key_code %h, wanted %h", rsp_tdata[6:0], want.code));
            if (rsp_tdata[22:7] != want.sym)
               log_mismatch($sformatf("key_symbol %h, wanted %h", rsp_tdata[22:7], want.sym));
            if (rsp_tdata[25:23] != want.mods)
               log_mismatch($sformatf("modifier_bits %b, wanted %b", rsp_tdata[25:23], want.mods));
            if (rsp_tdata[31:26] != 6'h0)
               log_mismatch($sformatf("padding bits %b not zero", rsp_tdata[31:26]));
            if (rsp_tuser[0] != want.press)
               log_mismatch($sformatf("is_press %b, wanted %b", rsp_tuser[0], want.press));
            if (rsp_tlast != want.last)
               log_mismatch($sformatf("last %b, wanted %b", rsp_tlast, want.last));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("timeout: no item moved for %0d cycles", quiet_cycles);
         $display("key_event_translator_tracker_core regression: fail");
         $finish;
      end
   end

   initial begin
      logic [7:0] episode_keys[$];
      logic [7:0] base;
      logic [31:0] raw;
      int k;
      int cut;
      bit dup;
      for (int i = 0; i < HELD_SLOTS; i++) begin
         held_valid[i] = 1'b0;
         held_id[i] = '0;
         held_ev[i] = '0;
      end
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (DIRECTED_ROWS[r]) begin
         send_key(DIRECTED_ROWS[r].raw, DIRECTED_ROWS[r].down, DIRECTED_ROWS[r].typed,
                  DIRECTED_ROWS[r].typed_has, DIRECTED_ROWS[r].ev);
      end

      // hold off until the block has drained
      req_tvalid <= 1'b0;
      while (pending_key_events.size() != 0) @(negedge clock);
      @(negedge clock);

      while (items_sent < RANDOM_TARGET) begin
         if ($urandom_range(9) < 2) begin
            raw = $urandom;
            if ($urandom_range(1)) raw &= RAW_LEGAL;
            send_key(raw, 1'($urandom_range(1)), 1'b0, 1'b0, NO_EVENT);
         end else begin
            k = ($urandom_range(3) == 0) ? $urandom_range(14, 17) : $urandom_range(1, 6);
            episode_keys.delete();
            while (episode_keys.size() < k) begin
               base = pick_valid_base();
               dup = 1'b0;
               foreach (episode_keys[j]) if (episode_keys[j] == base) dup = 1'b1;
               if (!dup) episode_keys.push_back(base);
            end
            foreach (episode_keys[j]) begin
               send_key(with_mods(episode_keys[j]), PRESS, 1'b0, 1'b0, NO_EVENT);
               if ($urandom_range(9) == 0)
                  send_key(with_mods(episode_keys[j]), PRESS, 1'b0, 1'b0, NO_EVENT);
            end
            episode_keys.shuffle();
            cut = $urandom_range(episode_keys.size());
            case ($urandom_range(3))
               0: begin
                  foreach (episode_keys[j])
                     send_key(with_mods(episode_keys[j]), RELEASE, 1'b0, 1'b0, NO_EVENT);
               end
               1: begin
                  for (int j = 0; j < cut; j++)
                     send_key(with_mods(episode_keys[j]), RELEASE, 1'b0, 1'b0, NO_EVENT);
                  send_key($urandom | 32'h8000_0000, RELEASE, 1'b0, 1'b0, NO_EVENT);
               end
               2: begin
                  for (int j = 0; j < cut; j++)
                     send_key(with_mods(episode_keys[j]), RELEASE, 1'b0, 1'b0, NO_EVENT);
                  send_key(with_mods(pick_valid_base()), RELEASE, 1'b0, 1'b0, NO_EVENT);
               end
               default: ;
            endcase
         end
      end

      req_tvalid <= 1'b0;
      calm = 1'b0;
      while (pending_key_events.size() != 0) @(negedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (pending_key_events.size() != 0)
         log_mismatch($sformatf("%0d results never arrived", pending_key_events.size()));

      $display("sent %0d items (%0d with results), checked %0d results",
               items_sent, effective_items, results_checked);
      $display("held table emptied %0d times, %0d of them by a press on a full table",
               table_flushes, full_flushes);
      if (mismatches == 0) begin
         $display("key_event_translator_tracker_core regression: pass");
      end else begin
         $display("key_event_translator_tracker_core regression: fail");
      end
      $finish;
   end

endmodule
